>>> rtl/gnnt_pkg.sv
// gnnt_pkg: shared types and constants for the greedy nearest neighbour tour block
// used by the request/result interfaces, the sequencer and the datapath
package gnnt_pkg;

  localparam int unsigned CityCountW = 5;
  localparam int unsigned FieldCityW = 4;
  localparam int unsigned CostW      = 10;
  localparam int unsigned TotalW     = 16;
  localparam int unsigned StepCntW   = 5;

  localparam logic [CityCountW-1:0] CityCountReset = 5'd16;
  localparam logic [CostW-1:0]      NoEdgeLimit    = 10'd999;
  localparam logic [TotalW-1:0]     TotalMax       = 16'hFFFF;
  // step results allowed before the closing result
  localparam logic [StepCntW-1:0]   StepLimit      = 5'd16;

  typedef enum logic {
    ActLoad = 1'b0,
    ActRun  = 1'b1
  } action_e;

  // sequencer to datapath
  typedef struct packed {
    logic load_wr;     // write the requested matrix entry
    logic run_init;    // mark only city 0 visited, clear the total, start at city 0
    logic scan_init;   // restart the row scan, forget the best candidate
    logic scan_rd;     // read the next entry of the current row
    logic close_rd;    // read the entry back to city 0
    logic step_take;   // move to the best candidate and post a step result
    logic close_take;  // add the return cost and post the closing result
  } cmd_t;

  // datapath to sequencer
  typedef struct packed {
    logic scan_last;   // the scan index points at the last city in use
    logic found;       // a candidate was found in the finished scan
    logic out_free;    // the result register can take a new result
  } sts_t;

endpackage

>>> rtl/gnnt_req_if.sv
// gnnt_req_if: request channel (matrix load or tour run)
// depends on gnnt_pkg for field widths
interface gnnt_req_if import gnnt_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [FieldCityW-1:0] row_city;
  logic [FieldCityW-1:0] col_city;
  logic [CostW-1:0]      entry_cost;

  modport source (output valid, action, row_city, col_city, entry_cost, input ready);
  modport sink   (input valid, action, row_city, col_city, entry_cost, output ready);

endinterface

>>> rtl/gnnt_res_if.sv
// gnnt_res_if: result channel (one tour step or the closing return)
// depends on gnnt_pkg for field widths
interface gnnt_res_if import gnnt_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [FieldCityW-1:0] visited_city;
  logic [TotalW-1:0]     total_cost;
  logic                  last;

  modport source (output valid, visited_city, total_cost, last, input ready);
  modport sink   (input valid, visited_city, total_cost, last, output ready);

endinterface

>>> rtl/gnnt_ctrl.sv
// gnnt_ctrl: sequencer for loads, row scans, steps and the closing return
// depends on gnnt_pkg for the command and status structs
module gnnt_ctrl import gnnt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_action_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StScan,
    StDrain,
    StDecide,
    StCloseRd,
    StCloseWait
  } state_e;

  state_e               state_q, state_d;
  logic [StepCntW-1:0]  step_cnt_q, step_cnt_d;
  logic                 req_acc;

  assign req_ready_o = (state_q == StIdle);
  assign req_acc     = req_valid_i && req_ready_o;

  always_comb begin
    state_d    = state_q;
    step_cnt_d = step_cnt_q;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        if (req_acc) begin
          if (req_action_i == ActRun) begin
            cmd_o.run_init = 1'b1;
            step_cnt_d     = '0;
            state_d        = StStart;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      StStart: begin
        cmd_o.scan_init = 1'b1;
        state_d         = StScan;
      end
      StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      // last compare of the row lands here
      StDrain: begin
        state_d = StDecide;
      end
      StDecide: begin
        if (!sts_i.found) begin
          state_d = StCloseRd;
        end else if (sts_i.out_free) begin
          cmd_o.step_take = 1'b1;
          step_cnt_d      = step_cnt_q + 1'b1;
          state_d         = (step_cnt_d == StepLimit) ? StCloseRd : StStart;
        end
      end
      StCloseRd: begin
        cmd_o.close_rd = 1'b1;
        state_d        = StCloseWait;
      end
      StCloseWait: begin
        if (sts_i.out_free) begin
          cmd_o.close_take = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      step_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      step_cnt_q <= step_cnt_d;
    end
  end

endmodule

>>> rtl/gnnt_dpath.sv
// gnnt_dpath: cost memory, scan compare, visited marks, tour total and result register
// depends on gnnt_pkg and gnnt_res_if
module gnnt_dpath import gnnt_pkg::*; #(
  parameter int unsigned MAX_CITIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic [CityCountW-1:0] cfg_wr_data_i,
  input  logic [FieldCityW-1:0] wr_row_i,
  input  logic [FieldCityW-1:0] wr_col_i,
  input  logic [CostW-1:0]      wr_cost_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  gnnt_res_if.source            res_o
);

  localparam int unsigned CityW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int unsigned NumW  = $clog2(MAX_CITIES + 1);
  localparam int unsigned AddrW = 2 * CityW;
  localparam int unsigned Depth = 2 ** AddrW;

  // rows are laid out on a power of two stride
  logic [CostW-1:0]      mem_q [Depth];
  logic [CostW-1:0]      rd_data_q;
  logic [AddrW-1:0]      rd_addr;

  logic [CityCountW-1:0] city_count_q;
  logic [NumW-1:0]       num_cities;
  logic [CityW-1:0]      last_idx;

  logic [CityW-1:0]      scan_idx_q;
  logic                  cmp_valid_q;
  logic [CityW-1:0]      cmp_idx_q;
  logic [CostW-1:0]      best_q;
  logic [CityW-1:0]      next_q;
  logic                  found_q;
  logic                  better;

  logic [MAX_CITIES-1:0] visited_q;
  logic [CityW-1:0]      cur_q;
  logic [TotalW-1:0]     total_q;
  logic [TotalW-1:0]     total_add;
  logic [CostW-1:0]      add_cost;
  logic [TotalW:0]       total_sum;

  logic                  out_valid_q;
  logic [FieldCityW-1:0] out_city_q;
  logic [TotalW-1:0]     out_total_q;
  logic                  out_last_q;

  // cities in use, clamped to the table size; none in use still scans city 0
  always_comb begin
    if (city_count_q > MAX_CITIES) begin
      num_cities = NumW'(MAX_CITIES);
    end else begin
      num_cities = NumW'(city_count_q);
    end
    if (num_cities == '0) begin
      last_idx = '0;
    end else begin
      last_idx = CityW'(num_cities - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= CityCountReset;
    end else if (cfg_wr_en_i) begin
      city_count_q <= cfg_wr_data_i;
    end
  end

  // cost memory: one write port, one registered read port
  assign rd_addr = cmd_i.scan_rd ? {cur_q, scan_idx_q} : {cur_q, CityW'(0)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && (wr_row_i < MAX_CITIES) && (wr_col_i < MAX_CITIES)) begin
      mem_q[{CityW'(wr_row_i), CityW'(wr_col_i)}] <= wr_cost_i;
    end
    if (cmd_i.scan_rd || cmd_i.close_rd) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // nearest unvisited candidate, lowest index wins on ties
  assign better = cmp_valid_q && (rd_data_q != '0) && !visited_q[cmp_idx_q]
                  && (rd_data_q < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      best_q      <= NoEdgeLimit;
      next_q      <= '0;
      found_q     <= 1'b0;
    end else begin
      cmp_valid_q <= cmd_i.scan_rd;
      cmp_idx_q   <= scan_idx_q;
      if (cmd_i.scan_init) begin
        scan_idx_q <= '0;
        best_q     <= NoEdgeLimit;
        found_q    <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        if (better) begin
          best_q  <= rd_data_q;
          next_q  <= cmp_idx_q;
          found_q <= 1'b1;
        end
      end
    end
  end

  // saturating total
  assign add_cost  = cmd_i.close_take ? rd_data_q : best_q;
  assign total_sum = {1'b0, total_q} + (TotalW + 1)'(add_cost);
  assign total_add = total_sum[TotalW] ? TotalMax : total_sum[TotalW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      cur_q     <= '0;
      total_q   <= '0;
    end else if (cmd_i.run_init) begin
      visited_q <= MAX_CITIES'(1);
      cur_q     <= '0;
      total_q   <= '0;
    end else if (cmd_i.step_take) begin
      visited_q[next_q] <= 1'b1;
      cur_q             <= next_q;
      total_q           <= total_add;
    end else if (cmd_i.close_take) begin
      cur_q   <= '0;
      total_q <= total_add;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step_take || cmd_i.close_take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_take) begin
      out_city_q  <= FieldCityW'(next_q);
      out_total_q <= total_add;
      out_last_q  <= 1'b0;
    end else if (cmd_i.close_take) begin
      out_city_q  <= '0;
      out_total_q <= total_add;
      out_last_q  <= 1'b1;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.visited_city = out_city_q;
  assign res_o.total_cost   = out_total_q;
  assign res_o.last         = out_last_q;

  assign sts_o.scan_last = (scan_idx_q == last_idx);
  assign sts_o.found     = found_q;
  assign sts_o.out_free  = !out_valid_q || res_o.ready;

endmodule

>>> rtl/greedy_nearest_neighbour_tour.sv
// greedy_nearest_neighbour_tour: top level, joins the sequencer and the datapath
// depends on gnnt_pkg, gnnt_req_if, gnnt_res_if, gnnt_ctrl and gnnt_dpath
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    action, row_city, col_city, entry_cost
//   res_o    out  valid/ready    visited_city, total_cost, last
//   cfg      in   cfg_wr_en_i    cfg_wr_data_i (city_count)
//
// a load request is written in the cycle it is accepted; a run does one row scan per step and
// one more that finds nothing unless the step limit is hit, then reads the return cost and
// posts the closing result; a scan is set by the single read port scanning one entry a cycle
// rst_ni clears control state, visited marks and total; the cost memory is not cleared
// req_i is ready only while no run is in progress; a result not yet taken holds
// the sequencer before the next result is posted
module greedy_nearest_neighbour_tour import gnnt_pkg::*; #(
  parameter int unsigned MAX_CITIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic [CityCountW-1:0] cfg_wr_data_i,
  gnnt_req_if.sink              req_i,
  gnnt_res_if.source            res_o
);

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  assign req_i.ready = req_ready;

  gnnt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_ready_o  (req_ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  gnnt_dpath #(
    .MAX_CITIES (MAX_CITIES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .wr_row_i      (req_i.row_city),
    .wr_col_i      (req_i.col_city),
    .wr_cost_i     (req_i.entry_cost),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_o         (res_o)
  );

endmodule

>>> sim/greedy_nearest_neighbour_tour_test.sv
// greedy_nearest_neighbour_tour_test: self-checking bench for the greedy tour block
// needs gnnt_pkg, gnnt_req_if, gnnt_res_if and the greedy_nearest_neighbour_tour rtl
// directed table first, then random matrix writes and tours, checked by a local predictor
`timescale 1ns / 100ps

module greedy_nearest_neighbour_tour_test;
  import gnnt_pkg::*;

  localparam int MaxCities  = 16;
  localparam int RandItems  = 150;
  localparam int SettleCyc  = 12;
  localparam int CycleLimit = 2_000_000;

  typedef struct packed {
    logic [FieldCityW-1:0] city;
    logic [TotalW-1:0]     total;
    logic                  last;
  } leg_t;

  typedef enum logic [1:0] {DoCfg, DoLoad, DoTour} stim_kind_e;

  typedef struct {
    stim_kind_e            kind;
    logic [CityCountW-1:0] cfg;
    logic [FieldCityW-1:0] row;
    logic [FieldCityW-1:0] col;
    logic [CostW-1:0]      cost;
    bit                    typed;
    leg_t                  want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_wr_en_i;
  logic [CityCountW-1:0] cfg_wr_data_i;

  gnnt_req_if req_if ();
  gnnt_res_if res_if ();

  greedy_nearest_neighbour_tour #(.MAX_CITIES(MaxCities)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .req_i         (req_if),
    .res_o         (res_if)
  );

  // predictor state
  logic [CostW-1:0]      cost_tab [MaxCities][MaxCities];
  logic [MaxCities-1:0]  cost_set [MaxCities];
  logic [CityCountW-1:0] cities_cfg;
  leg_t                  tour_legs_q [$];

  // run bookkeeping
  int        mismatches;
  int        reqs_sent;
  int        loads_sent;
  int        tours_sent;
  int        steps_chk;
  int        closes_chk;
  int        deepest;
  int        cycle_cnt;
  int        hold_cnt;
  bit        src_eager;
  bit        sink_eager;
  bit [31:0] cfg_values_seen;
  stim_row_t plan [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 17) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // zero, unreachable costs and small values for ties show up often
  function automatic logic [CostW-1:0] pick_cost();
    case ($urandom_range(0, 19))
      0, 1, 2:    return '0;
      3:          return CostW'($urandom_range(999, 1023));
      4, 5, 6, 7: return CostW'($urandom_range(1, 3));
      8:          return CostW'(998);
      default:    return CostW'($urandom_range(1, 998));
    endcase
  endfunction

  function automatic int cities_in_use();
    return (cities_cfg > MaxCities) ? MaxCities : int'(cities_cfg);
  endfunction

  function automatic logic [TotalW-1:0] add_capped(logic [TotalW-1:0] acc,
                                                   logic [CostW-1:0] c);
    logic [TotalW:0] s;
    s = {1'b0, acc} + (TotalW + 1)'(c);
    return s[TotalW] ? TotalMax : s[TotalW-1:0];
  endfunction

  task automatic plan_greedy_tour();
    logic [MaxCities-1:0] toured;
    logic [TotalW-1:0]    sum;
    logic [CostW-1:0]     best;
    int                   n, here, pick, legs;
    bit                   hit;
    n      = cities_in_use();
    toured = MaxCities'(1);
    here   = 0;
    sum    = '0;
    legs   = 0;
    while (legs < StepLimit) begin
      best = NoEdgeLimit;
      hit  = 1'b0;
      pick = 0;
      for (int i = 0; i < n; i++) begin
        if (cost_tab[here][i] != 0 && !toured[i] && cost_tab[here][i] < best) begin
          best = cost_tab[here][i];
          pick = i;
          hit  = 1'b1;
        end
      end
      if (!hit) break;
      sum          = add_capped(sum, best);
      toured[pick] = 1'b1;
      here         = pick;
      tour_legs_q.push_back('{city: FieldCityW'(pick), total: sum, last: 1'b0});
      legs++;
    end
    sum = add_capped(sum, cost_tab[here][0]);
    tour_legs_q.push_back('{city: '0, total: sum, last: 1'b1});
    if (legs > deepest) deepest = legs;
  endtask

  task automatic send_request(action_e act, logic [FieldCityW-1:0] row,
                              logic [FieldCityW-1:0] col, logic [CostW-1:0] cost,
                              bit typed, leg_t want);
    int gap;
    gap = src_eager ? 0 : idle_span();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.row_city   <= row;
    req_if.col_city   <= col;
    req_if.entry_cost <= cost;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    reqs_sent++;
    if (act == ActLoad) begin
      cost_tab[row][col] = cost;
      cost_set[row][col] = 1'b1;
      loads_sent++;
    end else begin
      tours_sent++;
      if (typed) tour_legs_q.push_back(want);
      else plan_greedy_tour();
    end
  endtask

  // a tour may only read entries already written, so fill the square in use first
  task automatic launch_tour(bit typed, leg_t want);
    int side;
    side = (cities_in_use() < 2) ? 2 : cities_in_use();
    for (int r = 0; r < side; r++)
      for (int c = 0; c < side; c++)
        if (!cost_set[r][c])
          send_request(ActLoad, FieldCityW'(r), FieldCityW'(c), pick_cost(), 1'b0, '0);
    send_request(ActRun, FieldCityW'($urandom), FieldCityW'($urandom),
                 CostW'($urandom), typed, want);
  endtask

  task automatic drain_requests();
    req_if.valid <= 1'b0;
    while (tour_legs_q.size() != 0) @(posedge clk_i);
    // a trailing matrix write gives no result, so let it land
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_city_count(logic [CityCountW-1:0] value);
    drain_requests();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    cities_cfg            = value;
    cfg_values_seen[value] = 1'b1;
  endtask

  function automatic stim_row_t stim_row(stim_kind_e kind, int cfg, int row, int col,
                                         int cost, bit typed, int total);
    stim_row_t s;
    s.kind  = kind;
    s.cfg   = CityCountW'(cfg);
    s.row   = FieldCityW'(row);
    s.col   = FieldCityW'(col);
    s.cost  = CostW'(cost);
    s.typed = typed;
    s.want  = '{city: '0, total: TotalW'(total), last: 1'b1};
    return s;
  endfunction

  task automatic flag_fault(string what, leg_t want, leg_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected city %0d total %0d last %0b, got city %0d total %0d last %0b",
               $realtime, what, want.city, want.total, want.last,
               got.city, got.total, got.last);
  endtask

  // result sink with random back-pressure
  always @(posedge clk_i) begin : result_sink
    int span;
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt     <= hold_cnt - 1;
        res_if.ready <= 1'b0;
      end else if (!sink_eager && $urandom_range(0, 3) == 0) begin
        span = idle_span();
        hold_cnt     <= span;
        res_if.ready <= (span == 0);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    leg_t got;
    leg_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{city: res_if.visited_city, total: res_if.total_cost, last: res_if.last};
      if (tour_legs_q.size() == 0) begin
        flag_fault("result with nothing pending", '0, got);
      end else begin
        want = tour_legs_q.pop_front();
        if (got.city !== want.city || got.total !== want.total || got.last !== want.last)
          flag_fault("tour result mismatch", want, got);
        if (want.last) closes_chk++;
        else steps_chk++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) sink_eager <= ($urandom_range(0, 3) == 0);
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, tour_legs_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int                    iter;
    int                    n;
    logic [CityCountW-1:0] cc;

    rst_ni            = 1'b0;
    cfg_wr_en_i       = 1'b0;
    cfg_wr_data_i     = '0;
    req_if.valid      = 1'b0;
    req_if.action     = ActLoad;
    req_if.row_city   = '0;
    req_if.col_city   = '0;
    req_if.entry_cost = '0;
    res_if.ready      = 1'b0;
    hold_cnt          = 0;
    cycle_cnt         = 0;
    src_eager         = 1'b0;
    sink_eager        = 1'b0;
    mismatches        = 0;
    reqs_sent         = 0;
    loads_sent        = 0;
    tours_sent        = 0;
    steps_chk         = 0;
    closes_chk        = 0;
    deepest           = 0;
    cities_cfg        = CityCountReset;
    cfg_values_seen   = '0;
    foreach (cost_set[r]) cost_set[r] = '0;

    // two cities, then the degenerate counts and the unreachable costs
    plan.push_back(stim_row(DoCfg,  2,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  0,  0,    7, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  0,  1,    5, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  1,  0,    9, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  1,  1,    0, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoCfg,  1,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 1, 7));
    plan.push_back(stim_row(DoCfg,  0,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 1, 7));
    plan.push_back(stim_row(DoCfg,  2,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  0,  1,  999, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 1, 7));
    plan.push_back(stim_row(DoLoad, 0,  0,  1, 1023, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 1, 7));
    plan.push_back(stim_row(DoLoad, 0,  0,  1,  998, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  1,  0, 1023, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoCfg,  1,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 1, 0));
    // equal costs out of city 0, lowest index has to win
    plan.push_back(stim_row(DoCfg,  4,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  0,  1,    0, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  0,  2,    3, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  0,  3,    3, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 0, 0));
    // full size and counts above the maximum
    plan.push_back(stim_row(DoCfg, 16,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoLoad, 0, 15, 15, 1023, 0, 0));
    plan.push_back(stim_row(DoLoad, 0,  0, 15,    1, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoCfg, 31,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoCfg, 17,  0,  0,    0, 0, 0));
    plan.push_back(stim_row(DoTour, 0,  0,  0,    0, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        DoCfg:   write_city_count(plan[i].cfg);
        DoLoad:  send_request(ActLoad, plan[i].row, plan[i].col, plan[i].cost, 1'b0, '0);
        default: launch_tour(plan[i].typed, plan[i].want);
      endcase
    end

    // random part: batches of matrix writes, each closed by a tour
    n    = reqs_sent + RandItems;
    iter = 0;
    while (reqs_sent < n) begin
      src_eager = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        // mostly small counts to keep tours short
        case ($urandom_range(0, 9))
          0:       cc = CityCountW'($urandom_range(0, 1));
          1:       cc = CityCountW'(16);
          2:       cc = CityCountW'($urandom_range(17, 31));
          3:       cc = CityCountW'($urandom_range(7, 15));
          default: cc = CityCountW'($urandom_range(2, 6));
        endcase
        write_city_count(cc);
      end
      if (iter == 6) drain_requests();
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 4) == 0 || cities_in_use() < 2)
          send_request(ActLoad, FieldCityW'($urandom), FieldCityW'($urandom),
                       pick_cost(), 1'b0, '0);
        else
          send_request(ActLoad, FieldCityW'($urandom_range(0, cities_in_use() - 1)),
                       FieldCityW'($urandom_range(0, cities_in_use() - 1)),
                       pick_cost(), 1'b0, '0);
      end
      launch_tour(1'b0, '0);
      iter++;
    end

    drain_requests();
    repeat (20) @(posedge clk_i);

    $display("%0d matrix writes, %0d tours; %0d step and %0d closing results compared",
             loads_sent, tours_sent, steps_chk, closes_chk);
    $display("%0d distinct city counts used, longest tour %0d steps, %0d mismatches",
             $countones(cfg_values_seen), deepest, mismatches);
    if (mismatches == 0 && tour_legs_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
